@@ rtl/lens_undistort_newton_top_macros.svh @@
// ----------------------------------------------------------------------------
// lens undistort assertion macros
// shared property wrappers for the checker, clocked by clock, off in reset
// ----------------------------------------------------------------------------
`ifndef LENS_UNDISTORT_NEWTON_TOP_MACROS_SVH
`define LENS_UNDISTORT_NEWTON_TOP_MACROS_SVH

// implication checked at every clock, off during reset
`define LUN_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m failed");

// next cycle implication
`define LUN_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m failed");

`endif

@@ rtl/lun_pkg.sv @@
// ----------------------------------------------------------------------------
// lun_pkg
// types and constants of the newton lens undistortion block
// ----------------------------------------------------------------------------
package lun_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned REG_IDX_W = 3;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam logic [REG_IDX_W-1:0] REG_K1 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_K2 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_K3 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_P1 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_P2 = 3'd4;

   localparam word_type WORD_MAX = 32'sh7fff_ffff;
   localparam word_type WORD_MIN = -32'sh7fff_ffff - 32'sd1;

   // saturate a 66-bit signed value to 32 bits
   function automatic word_type sat66(input logic signed [65:0] v);
      word_type r;
      if (v > 66'sd2147483647) begin
         r = WORD_MAX;
      end else if (v < -66'sd2147483648) begin
         r = WORD_MIN;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/lun_core.sv @@
// ----------------------------------------------------------------------------
// lun_core
// shared multiplier, adder and divider under a microcoded sequencer
// ----------------------------------------------------------------------------
module lun_core #(
   parameter int unsigned ITER_MAX = 100,
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  lun_pkg::word_type x0,
   input  lun_pkg::word_type y0,
   input  lun_pkg::word_type k1,
   input  lun_pkg::word_type k2,
   input  lun_pkg::word_type k3,
   input  lun_pkg::word_type p1,
   input  lun_pkg::word_type p2,
   output logic busy,
   output logic done,
   output lun_pkg::word_type res_x,
   output lun_pkg::word_type res_y,
   output logic res_conv
);

   localparam int unsigned IT_W = $clog2(ITER_MAX + 1);

   // register file slots
   localparam logic [4:0] R_X = 5'd0, R_Y = 5'd1, R_X2 = 5'd2, R_Y2 = 5'd3,
      R_R2 = 5'd4, R_XY = 5'd5, R_R4 = 5'd6, R_R6 = 5'd7, R_T = 5'd8,
      R_KR = 5'd9, R_XD = 5'd10, R_YD = 5'd11, R_F = 5'd12, R_G = 5'd13,
      R_JA = 5'd14, R_JB = 5'd15, R_JD = 5'd16, R_DET = 5'd17, R_NX = 5'd18,
      R_NY = 5'd19, R_XN = 5'd20, R_U = 5'd21, R_X0 = 5'd22, R_Y0 = 5'd23,
      R_K1 = 5'd24, R_K2 = 5'd25, R_K3 = 5'd26, R_P1 = 5'd27, R_P2 = 5'd28,
      R_ONE = 5'd29, R_T2 = 5'd30;
   localparam int unsigned NREG = 31;

   // ops
   localparam logic [2:0] OP_MUL = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2,
      OP_MULI = 3'd3, OP_DIV = 3'd4, OP_CHK = 3'd5, OP_NOP = 3'd6;

   // states
   localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_WAIT = 3'd2,
      S_DIV = 3'd3, S_DONE = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] a;
      logic [4:0] b;
      logic [4:0] d;
      logic [2:0] imm;
   } uop_type;

   localparam int unsigned NUOP = 86;
   localparam int unsigned PC_W = 7;

   function automatic uop_type u(input logic [2:0] op, input logic [4:0] a,
      input logic [4:0] b, input logic [4:0] d, input logic [2:0] imm);
      uop_type r;
      r.op = op; r.a = a; r.b = b; r.d = d; r.imm = imm;
      return r;
   endfunction

   function automatic uop_type prog(input logic [PC_W-1:0] pc);
      uop_type r;
      case (pc)
         7'd0:  r = u(OP_MUL, R_X, R_X, R_X2, 3'd0);
         7'd1:  r = u(OP_MUL, R_Y, R_Y, R_Y2, 3'd0);
         7'd2:  r = u(OP_ADD, R_X2, R_Y2, R_R2, 3'd0);
         7'd3:  r = u(OP_MUL, R_X, R_Y, R_XY, 3'd0);
         7'd4:  r = u(OP_MUL, R_R2, R_R2, R_R4, 3'd0);
         7'd5:  r = u(OP_MUL, R_R2, R_R4, R_R6, 3'd0);
         // kr
         7'd6:  r = u(OP_MUL, R_K3, R_R2, R_T, 3'd0);
         7'd7:  r = u(OP_ADD, R_T, R_K2, R_T, 3'd0);
         7'd8:  r = u(OP_MUL, R_T, R_R2, R_T, 3'd0);
         7'd9:  r = u(OP_ADD, R_T, R_K1, R_T, 3'd0);
         7'd10: r = u(OP_MUL, R_T, R_R2, R_T, 3'd0);
         7'd11: r = u(OP_ADD, R_T, R_ONE, R_KR, 3'd0);
         // xd
         7'd12: r = u(OP_MUL, R_X, R_KR, R_XD, 3'd0);
         7'd13: r = u(OP_MULI, R_X2, R_X2, R_T, 3'd2);
         7'd14: r = u(OP_ADD, R_R2, R_T, R_T, 3'd0);
         7'd15: r = u(OP_MUL, R_P2, R_T, R_T, 3'd0);
         7'd16: r = u(OP_ADD, R_XD, R_T, R_XD, 3'd0);
         7'd17: r = u(OP_MULI, R_P1, R_P1, R_T, 3'd2);
         7'd18: r = u(OP_MUL, R_T, R_XY, R_T, 3'd0);
         7'd19: r = u(OP_ADD, R_XD, R_T, R_XD, 3'd0);
         // yd
         7'd20: r = u(OP_MUL, R_Y, R_KR, R_YD, 3'd0);
         7'd21: r = u(OP_MULI, R_Y2, R_Y2, R_T, 3'd2);
         7'd22: r = u(OP_ADD, R_R2, R_T, R_T, 3'd0);
         7'd23: r = u(OP_MUL, R_P1, R_T, R_T, 3'd0);
         7'd24: r = u(OP_ADD, R_YD, R_T, R_YD, 3'd0);
         7'd25: r = u(OP_MULI, R_P2, R_P2, R_T, 3'd2);
         7'd26: r = u(OP_MUL, R_T, R_XY, R_T, 3'd0);
         7'd27: r = u(OP_ADD, R_YD, R_T, R_YD, 3'd0);
         7'd28: r = u(OP_SUB, R_XD, R_X0, R_F, 3'd0);
         7'd29: r = u(OP_SUB, R_YD, R_Y0, R_G, 3'd0);
         // ja
         7'd30: r = u(OP_MUL, R_K3, R_R6, R_JA, 3'd0);
         7'd31: r = u(OP_MULI, R_K3, R_K3, R_T, 3'd6);
         7'd32: r = u(OP_MUL, R_T, R_X2, R_T, 3'd0);
         7'd33: r = u(OP_ADD, R_K2, R_T, R_T, 3'd0);
         7'd34: r = u(OP_MUL, R_T, R_R4, R_T, 3'd0);
         7'd35: r = u(OP_ADD, R_JA, R_T, R_JA, 3'd0);
         7'd36: r = u(OP_MULI, R_K2, R_K2, R_T, 3'd4);
         7'd37: r = u(OP_MUL, R_T, R_X2, R_T, 3'd0);
         7'd38: r = u(OP_ADD, R_K1, R_T, R_T, 3'd0);
         7'd39: r = u(OP_MUL, R_T, R_R2, R_T, 3'd0);
         7'd40: r = u(OP_ADD, R_JA, R_T, R_JA, 3'd0);
         7'd41: r = u(OP_MULI, R_K1, R_K1, R_T, 3'd2);
         7'd42: r = u(OP_MUL, R_T, R_X2, R_T, 3'd0);
         7'd43: r = u(OP_ADD, R_JA, R_T, R_JA, 3'd0);
         7'd44: r = u(OP_MULI, R_P2, R_P2, R_T, 3'd6);
         7'd45: r = u(OP_MUL, R_T, R_X, R_T, 3'd0);
         7'd46: r = u(OP_ADD, R_JA, R_T, R_JA, 3'd0);
         7'd47: r = u(OP_MULI, R_P1, R_P1, R_T, 3'd2);
         7'd48: r = u(OP_MUL, R_T, R_Y, R_T, 3'd0);
         7'd49: r = u(OP_ADD, R_JA, R_T, R_JA, 3'd0);
         7'd50: r = u(OP_ADD, R_JA, R_ONE, R_JA, 3'd0);
         // jb
         7'd51: r = u(OP_MULI, R_K3, R_K3, R_T, 3'd6);
         7'd52: r = u(OP_MUL, R_T, R_XY, R_T, 3'd0);
         7'd53: r = u(OP_MUL, R_T, R_R4, R_JB, 3'd0);
         7'd54: r = u(OP_MULI, R_K2, R_K2, R_T, 3'd4);
         7'd55: r = u(OP_MUL, R_T, R_XY, R_T, 3'd0);
         7'd56: r = u(OP_MUL, R_T, R_R2, R_T, 3'd0);
         7'd57: r = u(OP_ADD, R_JB, R_T, R_JB, 3'd0);
         7'd58: r = u(OP_MULI, R_K1, R_K1, R_T, 3'd2);
         7'd59: r = u(OP_MUL, R_T, R_XY, R_T, 3'd0);
         7'd60: r = u(OP_ADD, R_JB, R_T, R_JB, 3'd0);
         7'd61: r = u(OP_MULI, R_P1, R_P1, R_T, 3'd2);
         7'd62: r = u(OP_MUL, R_T, R_X, R_T, 3'd0);
         7'd63: r = u(OP_ADD, R_JB, R_T, R_JB, 3'd0);
         7'd64: r = u(OP_MULI, R_P2, R_P2, R_T, 3'd2);
         7'd65: r = u(OP_MUL, R_T, R_Y, R_T, 3'd0);
         7'd66: r = u(OP_ADD, R_JB, R_T, R_JB, 3'd0);
         // jd
         7'd67: r = u(OP_MUL, R_K3, R_R6, R_JD, 3'd0);
         7'd68: r = u(OP_MULI, R_K3, R_K3, R_T, 3'd6);
         7'd69: r = u(OP_MUL, R_T, R_Y2, R_T, 3'd0);
         7'd70: r = u(OP_ADD, R_K2, R_T, R_T, 3'd0);
         7'd71: r = u(OP_MUL, R_T, R_R4, R_T, 3'd0);
         7'd72: r = u(OP_ADD, R_JD, R_T, R_JD, 3'd0);
         7'd73: r = u(OP_MULI, R_K2, R_K2, R_T, 3'd4);
         7'd74: r = u(OP_MUL, R_T, R_Y2, R_T, 3'd0);
         7'd75: r = u(OP_ADD, R_K1, R_T, R_T, 3'd0);
         7'd76: r = u(OP_MUL, R_T, R_R2, R_T, 3'd0);
         7'd77: r = u(OP_ADD, R_JD, R_T, R_JD, 3'd0);
         7'd78: r = u(OP_MULI, R_K1, R_K1, R_T, 3'd2);
         7'd79: r = u(OP_MUL, R_T, R_Y2, R_T, 3'd0);
         7'd80: r = u(OP_ADD, R_JD, R_T, R_JD, 3'd0);
         7'd81: r = u(OP_MULI, R_P2, R_P2, R_T, 3'd2);
         7'd82: r = u(OP_MUL, R_T, R_X, R_T, 3'd0);
         7'd83: r = u(OP_ADD, R_JD, R_T, R_JD, 3'd0);
         7'd84: r = u(OP_MULI, R_P1, R_P1, R_T, 3'd6);
         7'd85: r = u(OP_MUL, R_T, R_Y, R_T, 3'd0);
         default: r = u(OP_NOP, R_X, R_X, R_X, 3'd0);
      endcase
      return r;
   endfunction

   // second program: jd tail, det, numerators, divisions, check
   function automatic uop_type prog2(input logic [4:0] pc);
      uop_type r;
      case (pc)
         5'd0:  r = u(OP_ADD, R_JD, R_T, R_JD, 3'd0);
         5'd1:  r = u(OP_ADD, R_JD, R_ONE, R_JD, 3'd0);
         5'd2:  r = u(OP_MUL, R_JA, R_JD, R_T, 3'd0);
         5'd3:  r = u(OP_MUL, R_JB, R_JB, R_T2, 3'd0);
         5'd4:  r = u(OP_SUB, R_T, R_T2, R_DET, 3'd0);
         5'd5:  r = u(OP_CHK, R_DET, R_DET, R_DET, 3'd0);
         5'd6:  r = u(OP_MUL, R_JD, R_F, R_T, 3'd0);
         5'd7:  r = u(OP_MUL, R_JB, R_G, R_T2, 3'd0);
         5'd8:  r = u(OP_SUB, R_T, R_T2, R_NX, 3'd0);
         5'd9:  r = u(OP_MUL, R_JA, R_G, R_T, 3'd0);
         5'd10: r = u(OP_MUL, R_JB, R_F, R_T2, 3'd0);
         5'd11: r = u(OP_SUB, R_T, R_T2, R_NY, 3'd0);
         5'd12: r = u(OP_DIV, R_NX, R_DET, R_T, 3'd0);
         5'd13: r = u(OP_SUB, R_X, R_T, R_XN, 3'd0);
         5'd14: r = u(OP_DIV, R_NY, R_DET, R_T, 3'd0);
         5'd15: r = u(OP_SUB, R_Y, R_T, R_U, 3'd0);
         default: r = u(OP_NOP, R_X, R_X, R_X, 3'd0);
      endcase
      return r;
   endfunction

   localparam int unsigned NUOP2 = 16;
   localparam int unsigned DIV_N = 32 + FRAC_BITS + 1;
   localparam int unsigned DCNT_W = $clog2(DIV_N + 1);

   lun_pkg::word_type rf_ff [NREG];
   lun_pkg::word_type rf_in [NREG];
   logic [2:0] state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic phase_ff, phase_in;
   logic [IT_W-1:0] it_ff, it_in;
   logic conv_ff, conv_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [4:0] pend_d_ff, pend_d_in;
   // divider
   logic [DIV_N-1:0] dq_ff, dq_in;
   logic [32:0] drem_ff, drem_in;
   logic [31:0] dden_ff, dden_in;
   logic dneg_ff, dneg_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   uop_type cur;
   lun_pkg::word_type opa, opb;
   logic signed [65:0] addv, mulr;
   logic signed [63:0] rnd;
   logic [63:0] nabs;
   logic [32:0] trial;
   logic signed [65:0] qs;
   logic [32:0] dfx, dfy;

   always_comb begin
      cur = phase_ff ? prog2(pc_ff[4:0]) : prog(pc_ff);
      opa = rf_ff[cur.a];
      opb = rf_ff[cur.b];
      rnd = prod_ff + (64'sd1 <<< (FRAC_BITS - 1));
      mulr = 66'(rnd >>> FRAC_BITS);
      nabs = (opa[31] ? 64'(-65'(opa)) : 64'(opa)) << FRAC_BITS;
      trial = {drem_ff[31:0], dq_ff[DIV_N-1]} - {1'b0, dden_ff};
      qs = dneg_ff ? -66'({1'b0, dq_ff}) : 66'({1'b0, dq_ff});
      dfx = 33'(rf_ff[R_XN]) - 33'(rf_ff[R_X]);
      dfy = 33'(rf_ff[R_U]) - 33'(rf_ff[R_Y]);
      addv = '0;
      case (cur.op)
         OP_ADD:  addv = 66'(opa) + 66'(opb);
         OP_SUB:  addv = 66'(opa) - 66'(opb);
         OP_MULI: addv = 66'(opa) * 66'(signed'({63'd0, cur.imm}));
         default: addv = '0;
      endcase
   end

   always_comb begin
      rf_in = rf_ff;
      state_in = state_ff;
      pc_in = pc_ff;
      phase_in = phase_ff;
      it_in = it_ff;
      conv_in = conv_ff;
      prod_in = prod_ff;
      pend_d_in = pend_d_ff;
      dq_in = dq_ff;
      drem_in = drem_ff;
      dden_in = dden_ff;
      dneg_in = dneg_ff;
      dcnt_in = dcnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rf_in[R_X] = x0; rf_in[R_Y] = y0;
               rf_in[R_X0] = x0; rf_in[R_Y0] = y0;
               rf_in[R_K1] = k1; rf_in[R_K2] = k2; rf_in[R_K3] = k3;
               rf_in[R_P1] = p1; rf_in[R_P2] = p2;
               rf_in[R_ONE] = 32'sd1 <<< FRAC_BITS;
               pc_in = '0;
               phase_in = 1'b0;
               it_in = '0;
               conv_in = 1'b0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cur.op)
               OP_MUL: begin
                  prod_in = 64'(opa) * 64'(opb);
                  pend_d_in = cur.d;
                  state_in = S_WAIT;
               end
               OP_ADD, OP_SUB, OP_MULI: begin
                  rf_in[cur.d] = lun_pkg::sat66(addv);
               end
               OP_CHK: begin
                  if (opa == '0) begin
                     state_in = S_DONE;
                  end
               end
               OP_DIV: begin
                  dq_in = DIV_N'(nabs);
                  drem_in = '0;
                  dden_in = opb[31] ? 32'(-33'(opb)) : 32'(opb);
                  dneg_in = opa[31] ^ opb[31];
                  dcnt_in = '0;
                  pend_d_in = cur.d;
                  state_in = S_DIV;
               end
               default: begin
                  // end of iteration: compare, then loop or finish
                  rf_in[R_X] = rf_ff[R_XN];
                  rf_in[R_Y] = rf_ff[R_U];
                  it_in = it_ff + 1'b1;
                  if ((dfx == 33'd0 || dfx == 33'd1 || dfx == '1) &&
                      (dfy == 33'd0 || dfy == 33'd1 || dfy == '1)) begin
                     conv_in = 1'b1;
                     state_in = S_DONE;
                  end else if (32'(it_ff) + 32'd1 >= 32'(ITER_MAX)) begin
                     state_in = S_DONE;
                  end
               end
            endcase
            if (state_in == S_EXEC || state_in == S_WAIT || state_in == S_DIV) begin
               if (cur.op == OP_NOP) begin
                  pc_in = '0;
                  phase_in = 1'b0;
               end else if (!phase_ff && pc_ff == PC_W'(NUOP - 1)) begin
                  pc_in = '0;
                  phase_in = 1'b1;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            if (!phase_ff) begin
               // phase one ends at prog index NUOP-1; prog2 runs up to NUOP2
               if (pc_ff == PC_W'(NUOP - 1)) begin
                  phase_in = (state_in == S_DONE) ? phase_ff : 1'b1;
               end
            end else if (pc_ff == PC_W'(NUOP2) && cur.op == OP_NOP) begin
               phase_in = 1'b0;
            end
         end
         S_WAIT: begin
            rf_in[pend_d_ff] = lun_pkg::sat66(mulr);
            state_in = S_EXEC;
         end
         S_DIV: begin
            if (!trial[32]) begin
               drem_in = trial;
               dq_in = {dq_ff[DIV_N-2:0], 1'b1};
            end else begin
               drem_in = {drem_ff[31:0], dq_ff[DIV_N-1]};
               dq_in = {dq_ff[DIV_N-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_N)) begin
               dq_in = dq_ff;
               drem_in = drem_ff;
               rf_in[pend_d_ff] = lun_pkg::sat66(qs);
               state_in = S_EXEC;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= '0;
         phase_ff <= 1'b0;
         it_ff <= '0;
         conv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         phase_ff <= phase_in;
         it_ff <= it_in;
         conv_ff <= conv_in;
      end
      rf_ff <= rf_in;
      prod_ff <= prod_in;
      pend_d_ff <= pend_d_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      dden_ff <= dden_in;
      dneg_ff <= dneg_in;
      dcnt_ff <= dcnt_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);
   assign res_x = rf_ff[R_X];
   assign res_y = rf_ff[R_Y];
   assign res_conv = conv_ff;

endmodule

@@ rtl/lens_undistort_newton_top.sv @@
// ----------------------------------------------------------------------------
// lens_undistort_newton_top
// inverse brown-conrady lens distortion by newton iteration, Q8.24
// ----------------------------------------------------------------------------
// One item at a time through a single shared 32x32 multiplier, saturating adder
// and a radix-2 restoring divider under a microcode sequencer. A newton
// iteration runs 86 + 17 micro-ops, among them 43 multiplies that each pass
// through a wait state, and two divisions. The iteration count (at most
// ITER_MAX, fewer on convergence, and cut short inside the step on a zero
// determinant) sets the latency. req_ready is low from acceptance until the
// result is taken.
module lens_undistort_newton_top #(
   parameter int unsigned ITER_MAX = 100,
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [lun_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [lun_pkg::WORD_W-1:0] csr_wdata,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [31:0] req_dist_x,
   input  logic signed [31:0] req_dist_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_undist_x,
   output logic signed [31:0] rsp_undist_y,
   output logic rsp_converged
);

   lun_pkg::word_type k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;
   logic rsp_valid_ff, rsp_valid_in;
   lun_pkg::word_type ox_ff, oy_ff;
   logic oc_ff;
   logic busy, done, start, rconv;
   lun_pkg::word_type rx, ry;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= '0; k2_ff <= '0; k3_ff <= '0; p1_ff <= '0; p2_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lun_pkg::REG_K1: k1_ff <= csr_wdata;
            lun_pkg::REG_K2: k2_ff <= csr_wdata;
            lun_pkg::REG_K3: k3_ff <= csr_wdata;
            lun_pkg::REG_P1: p1_ff <= csr_wdata;
            lun_pkg::REG_P2: p2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !busy && !rsp_valid_ff;
   assign start = req_valid && req_ready;

   lun_core #(.ITER_MAX(ITER_MAX), .FRAC_BITS(FRAC_BITS)) u_core (
      .clock(clock), .reset(reset), .start(start),
      .x0(req_dist_x), .y0(req_dist_y),
      .k1(k1_ff), .k2(k2_ff), .k3(k3_ff), .p1(p1_ff), .p2(p2_ff),
      .busy(busy), .done(done), .res_x(rx), .res_y(ry), .res_conv(rconv)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done) begin
         ox_ff <= rx;
         oy_ff <= ry;
         oc_ff <= rconv;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_undist_x = ox_ff;
   assign rsp_undist_y = oy_ff;
   assign rsp_converged = oc_ff;

endmodule

@@ rtl/lun_checker.sv @@
// ----------------------------------------------------------------------------
// lun_checker
// port-level checks of the newton undistortion block
// ----------------------------------------------------------------------------
`include "lens_undistort_newton_top_macros.svh"

module lun_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_converged
);

   // one item in flight: no acceptance while a result waits
   `LUN_ASSERT_IMP(a_no_accept_while_rsp, rsp_valid, !req_ready)
   // an accepted item blocks the input next cycle
   `LUN_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // result held until taken
   `LUN_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_converged))

endmodule

bind lens_undistort_newton_top lun_checker u_lun_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_converged(rsp_converged)
);

@@ test/lens_undistort_newton_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_undistort_newton_top_tb
// self-checking bench for the newton lens undistortion block: a queue-fed
// driver and a monitor with random idling, a bit-true fixed point predictor
// of the newton search, and register phases from zero through typical lens
// settings to the saturating extremes
// ----------------------------------------------------------------------------
module lens_undistort_newton_top_tb;

   localparam int FRAC = 24;
   localparam int ITER_LIMIT = 100;
   localparam int ONE = 1 << FRAC;
   localparam logic [lun_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd5;
   localparam logic [lun_pkg::REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

   typedef struct {
      lun_pkg::word_type x;
      lun_pkg::word_type y;
   } point_type;

   typedef struct {
      lun_pkg::word_type x;
      lun_pkg::word_type y;
      logic conv;
   } undist_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [lun_pkg::REG_IDX_W-1:0] csr_index;
   logic [lun_pkg::WORD_W-1:0] csr_wdata;
   logic req_valid;
   logic req_ready;
   logic signed [31:0] req_dist_x;
   logic signed [31:0] req_dist_y;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_undist_x;
   logic signed [31:0] rsp_undist_y;
   logic rsp_converged;

   lens_undistort_newton_top u_top (.*);

   int k1, k2, k3, p1, p2;
   point_type pending_points[$];
   undist_type expected_points[$];
   bit req_idle_en = 1;
   bit rsp_idle_en = 1;
   bit sender_hold = 0;
   int stall_len = 0;
   int stall_seq = 0;
   int errors = 0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int fx_sat(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   function automatic int fx_add(int a, int b);
      return fx_sat(longint'(a) + longint'(b));
   endfunction

   function automatic int fx_sub(int a, int b);
      return fx_sat(longint'(a) - longint'(b));
   endfunction

   function automatic int fx_muli(int a, int n);
      return fx_sat(longint'(a) * longint'(n));
   endfunction

   function automatic int fx_mul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
      return fx_sat(p >>> FRAC);
   endfunction

   function automatic int fx_div(int n, int d);
      longint num;
      num = longint'(n) * (longint'(1) <<< FRAC);
      return fx_sat(num / longint'(d));
   endfunction

   function automatic undist_type undistort(point_type pt);
      int x0, y0, x, y, x2, y2, r2, xy, r4, r6, kr, xd, yd, f, g;
      int ja, jb, jd, det, nx, ny, xn, yn;
      longint ddx, ddy;
      undist_type res;
      x0 = pt.x;
      y0 = pt.y;
      x = x0;
      y = y0;
      res.conv = 1'b0;
      for (int it = 0; it < ITER_LIMIT; it++) begin
         x2 = fx_mul(x, x);
         y2 = fx_mul(y, y);
         r2 = fx_add(x2, y2);
         xy = fx_mul(x, y);
         r4 = fx_mul(r2, r2);
         r6 = fx_mul(r2, r4);
         kr = fx_add(fx_mul(fx_add(fx_mul(fx_add(fx_mul(k3, r2), k2), r2), k1), r2), ONE);
         xd = fx_add(fx_add(fx_mul(x, kr), fx_mul(p2, fx_add(r2, fx_muli(x2, 2)))),
                     fx_mul(fx_muli(p1, 2), xy));
         yd = fx_add(fx_add(fx_mul(y, kr), fx_mul(p1, fx_add(r2, fx_muli(y2, 2)))),
                     fx_mul(fx_muli(p2, 2), xy));
         f = fx_sub(xd, x0);
         g = fx_sub(yd, y0);

         ja = fx_mul(k3, r6);
         ja = fx_add(ja, fx_mul(fx_add(k2, fx_mul(fx_muli(k3, 6), x2)), r4));
         ja = fx_add(ja, fx_mul(fx_add(k1, fx_mul(fx_muli(k2, 4), x2)), r2));
         ja = fx_add(ja, fx_mul(fx_muli(k1, 2), x2));
         ja = fx_add(ja, fx_mul(fx_muli(p2, 6), x));
         ja = fx_add(ja, fx_mul(fx_muli(p1, 2), y));
         ja = fx_add(ja, ONE);

         jb = fx_mul(fx_mul(fx_muli(k3, 6), xy), r4);
         jb = fx_add(jb, fx_mul(fx_mul(fx_muli(k2, 4), xy), r2));
         jb = fx_add(jb, fx_mul(fx_muli(k1, 2), xy));
         jb = fx_add(jb, fx_mul(fx_muli(p1, 2), x));
         jb = fx_add(jb, fx_mul(fx_muli(p2, 2), y));

         jd = fx_mul(k3, r6);
         jd = fx_add(jd, fx_mul(fx_add(k2, fx_mul(fx_muli(k3, 6), y2)), r4));
         jd = fx_add(jd, fx_mul(fx_add(k1, fx_mul(fx_muli(k2, 4), y2)), r2));
         jd = fx_add(jd, fx_mul(fx_muli(k1, 2), y2));
         jd = fx_add(jd, fx_mul(fx_muli(p2, 2), x));
         jd = fx_add(jd, fx_mul(fx_muli(p1, 6), y));
         jd = fx_add(jd, ONE);

         det = fx_sub(fx_mul(ja, jd), fx_mul(jb, jb));
         if (det == 0) break;

         nx = fx_sub(fx_mul(jd, f), fx_mul(jb, g));
         ny = fx_sub(fx_mul(ja, g), fx_mul(jb, f));
         xn = fx_sub(x, fx_div(nx, det));
         yn = fx_sub(y, fx_div(ny, det));
         ddx = longint'(xn) - longint'(x);
         ddy = longint'(yn) - longint'(y);
         x = xn;
         y = yn;
         if (ddx >= -1 && ddx <= 1 && ddy >= -1 && ddy <= 1) begin
            res.conv = 1'b1;
            break;
         end
      end
      res.x = x;
      res.y = y;
      return res;
   endfunction

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      point_type pt;
      bit fire;
      if (reset) begin
         req_valid <= 1'b0;
         req_dist_x <= '0;
         req_dist_y <= '0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            pt = pending_points.pop_front();
            expected_points.push_back(undistort(pt));
            req_gap = req_idle_en ? $urandom_range(0, 15) : 0;
         end
         if (req_valid && !fire) begin
            req_valid <= 1'b1;
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_points.size() > 0 && !sender_hold) begin
            req_valid <= 1'b1;
            req_dist_x <= pending_points[0].x;
            req_dist_y <= pending_points[0].y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   int stall_left = 0;
   int stall_seen = 0;
   always @(posedge clock) begin
      undist_type exp_pt;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_gap = rsp_idle_en ? $urandom_range(0, 15) : 0;
            if (expected_points.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected item x=%0d y=%0d conv=%0b",
                           rsp_undist_x, rsp_undist_y, rsp_converged);
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_undist_x !== exp_pt.x || rsp_undist_y !== exp_pt.y ||
                   rsp_converged !== exp_pt.conv) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected x=%0d y=%0d conv=%0b, got x=%0d y=%0d conv=%0b",
                              exp_pt.x, exp_pt.y, exp_pt.conv,
                              rsp_undist_x, rsp_undist_y, rsp_converged);
               end
            end
         end
         if (stall_seq != stall_seen) begin
            stall_seen = stall_seq;
            stall_left = stall_len;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(logic [lun_pkg::REG_IDX_W-1:0] idx, int val);
      case (idx)
         lun_pkg::REG_K1: k1 = val;
         lun_pkg::REG_K2: k2 = val;
         lun_pkg::REG_K3: k3 = val;
         lun_pkg::REG_P1: p1 = val;
         lun_pkg::REG_P2: p2 = val;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_lens(int a, int b, int c, int d, int e);
      write_reg(lun_pkg::REG_K1, a);
      write_reg(lun_pkg::REG_K2, b);
      write_reg(lun_pkg::REG_K3, c);
      write_reg(lun_pkg::REG_P1, d);
      write_reg(lun_pkg::REG_P2, e);
   endtask

   task automatic wait_drained();
      while (pending_points.size() != 0 || expected_points.size() != 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic add_point(int x, int y);
      point_type pt;
      pt.x = x;
      pt.y = y;
      pending_points.push_back(pt);
   endtask

   // signed value uniform in +-mag
   function automatic int spread(int mag);
      return int'($urandom_range(0, 2 * mag)) - mag;
   endfunction

   task automatic random_lens();
      set_lens(spread(ONE / 2), spread(ONE / 4), spread(ONE / 16),
               spread(ONE / 64), spread(ONE / 64));
   endtask

   task automatic random_points(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0)
            add_point($urandom, $urandom);
         else
            add_point(spread(ONE), spread(ONE));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      k1 = 0; k2 = 0; k3 = 0; p1 = 0; p2 = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients: identity map, extremes of the inputs
      add_point(0, 0);
      add_point(32'h7fffffff, 32'h7fffffff);
      add_point(32'h80000000, 32'h80000000);
      add_point(32'h7fffffff, 32'h80000000);
      add_point(ONE, -ONE);
      add_point(1, -1);
      wait_drained();

      // det zero at the first step
      set_lens(-ONE, 0, 0, 0, 0);
      add_point(ONE, 0);
      add_point(0, ONE);
      wait_drained();

      // typical barrel lens with tangential terms
      set_lens(-ONE / 4, ONE / 16, -ONE / 100, ONE / 500, -ONE / 700);
      add_point(ONE / 2, ONE / 3);
      add_point(-ONE, ONE);
      add_point(ONE / 10, -ONE / 5);
      wait_drained();

      // saturating extremes
      set_lens(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      add_point(ONE, ONE);
      add_point(32'h7fffffff, 32'h7fffffff);
      add_point(0, 0);
      wait_drained();
      set_lens(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      add_point(ONE, ONE);
      add_point(32'h80000000, 32'h7fffffff);
      add_point(0, 0);
      wait_drained();

      // ignored register index with every data bit toggled
      write_reg(REG_UNUSED, 32'hffffffff);
      write_reg(REG_UNUSED_HI, 32'h0);
      set_lens($urandom, $urandom, $urandom, $urandom, $urandom);
      random_points(4);
      wait_drained();

      // random lenses, with phases without idling and with pressure
      for (int ph = 0; ph < 16; ph++) begin
         random_lens();
         req_idle_en = (ph % 4 != 1);
         rsp_idle_en = (ph % 4 != 2);
         if (ph == 3) begin
            stall_len = 4000;
            stall_seq++;
         end
         random_points(50);
         if (ph == 5) begin
            sender_hold = 1'b1;
            wait (expected_points.size() == 0 && !req_valid);
            @(posedge clock);
            sender_hold = 1'b0;
         end
         random_points(50);
         wait_drained();
      end

      if (errors == 0 && expected_points.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #1000000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
